[rtl/lsd_pkg.sv]
// Shared types, limits and codes of the pixel decoder.
package lsd_pkg;

  localparam int unsigned HEADER_LIMIT     = 1024;
  localparam int unsigned FILENAME_LIMIT   = 256;
  localparam int unsigned SIZE_DIGIT_LIMIT = 32;

  // Header character index and delimiter index never exceed HEADER_LIMIT - 1.
  localparam int unsigned HDR_CNT_W  = $clog2(HEADER_LIMIT);
  localparam int unsigned SIZE_W     = 63;
  localparam int unsigned RUN_W      = 6;

  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_NINE       = 8'h39;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] PREFIX [4]      = '{8'h70, 8'h6E, 8'h67, 8'h5F};

  typedef enum logic [1:0] {
    KIND_HDR_CHAR = 2'd0,
    KIND_HDR_DONE = 2'd1,
    KIND_MSG_BYTE = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_PREFIX    = 4'd1,
    ERR_OVERLONG  = 4'd2,
    ERR_NO_DELIM  = 4'd3,
    ERR_DIGITS    = 4'd4,
    ERR_ZERO_SIZE = 4'd5,
    ERR_OVERFLOW  = 4'd6,
    ERR_FILENAME  = 4'd7,
    ERR_TRUNCATED = 4'd8
  } err_e;

  typedef struct packed {
    logic [7:0] green;
    logic [7:0] blue;
    logic       start_of_image;
    logic       end_of_image;
  } pixel_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    kind_e             kind;
    err_e              error_code;
    logic [SIZE_W-1:0] payload_size;
    logic [7:0]        filename_length;
    logic              last;
  } result_t;

endpackage

[rtl/lsd_if.sv]
// Channel interfaces of the pixel decoder: pixels in, results out, configuration write.
interface lsd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] green;
  logic [7:0] blue;
  logic       start_of_image;
  logic       end_of_image;

  modport source (output valid, green, blue, start_of_image, end_of_image, input ready);
  modport sink   (input valid, green, blue, start_of_image, end_of_image, output ready);
endinterface

interface lsd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [3:0]  error_code;
  logic [62:0] payload_size;
  logic [7:0]  filename_length;
  logic        last;

  modport source (output valid, out_byte, kind, error_code, payload_size, filename_length,
                  last, input ready);
  modport sink   (input valid, out_byte, kind, error_code, payload_size, filename_length,
                  last, output ready);
endinterface

interface lsd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] rotation;

  modport source (output valid, rotation, input ready);
  modport sink   (input valid, rotation, output ready);
endinterface

[rtl/lsd_in_stage.sv]
// Input register stage holding one pixel until the decode core takes it.
module lsd_in_stage
  import lsd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  pixel_t in_pixel_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output pixel_t out_pixel_o
);

  logic   valid_q, valid_d;
  pixel_t pixel_q, pixel_d;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    pixel_d = pixel_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      pixel_d = in_pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q <= pixel_d;
  end

  assign out_valid_o = valid_q;
  assign out_pixel_o = pixel_q;

endmodule

[rtl/lsd_core.sv]
// Decode core: byte assembly, header parsing, message counting and the result register.
module lsd_core
  import lsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rotation_i,
  input  logic       pix_valid_i,
  output logic       pix_ready_o,
  input  pixel_t     pix_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_o
);

  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_MESSAGE = 2'd1;
  localparam logic [1:0] MODE_IDLE    = 2'd2;

  logic [1:0]           phase_q, phase_d, e_phase;
  logic [7:0]           acc_q, acc_d, e_acc;
  logic [1:0]           mode_q, mode_d, e_mode;
  logic [HDR_CNT_W-1:0] hc_q, hc_d, e_hc;
  logic                 pok_q, pok_d, e_pok;
  logic [RUN_W-1:0]     run_q, run_d, e_run;
  logic                 rad_q, rad_d, e_rad;
  logic [HDR_CNT_W-1:0] delim_q, delim_d, e_delim;
  logic [SIZE_W-1:0]    size_q, size_d, e_size;
  logic                 ovf_q, ovf_d, e_ovf;
  logic [SIZE_W-1:0]    br_q, br_d, e_br;

  logic                 res_valid_q, res_valid_d;
  result_t              res_q, res_d;

  logic                 fire;
  logic                 emit;
  result_t              step_res;
  logic [7:0]           acc_new;
  logic [7:0]           chr;
  logic [SIZE_W+3:0]    prod;
  logic [SIZE_W-1:0]    br_dec;
  logic                 hdr_end;
  logic                 hdr_err;
  err_e                 hdr_code;
  logic [7:0]           fname;

  assign pix_ready_o = !res_valid_q || res_ready_i;
  assign fire        = pix_valid_i && pix_ready_o;

  always_comb begin
    // A start of image restarts the decoder before this pixel is used.
    e_phase = pix_i.start_of_image ? 2'd0          : phase_q;
    e_acc   = pix_i.start_of_image ? 8'd0          : acc_q;
    e_mode  = pix_i.start_of_image ? MODE_HEADER   : mode_q;
    e_hc    = pix_i.start_of_image ? '0            : hc_q;
    e_pok   = pix_i.start_of_image ? 1'b1          : pok_q;
    e_run   = pix_i.start_of_image ? '0            : run_q;
    e_rad   = pix_i.start_of_image ? 1'b0          : rad_q;
    e_delim = pix_i.start_of_image ? '0            : delim_q;
    e_size  = pix_i.start_of_image ? '0            : size_q;
    e_ovf   = pix_i.start_of_image ? 1'b0          : ovf_q;
    e_br    = pix_i.start_of_image ? '0            : br_q;

    phase_d = e_phase;
    acc_d   = e_acc;
    mode_d  = e_mode;
    hc_d    = e_hc;
    pok_d   = e_pok;
    run_d   = e_run;
    rad_d   = e_rad;
    delim_d = e_delim;
    size_d  = e_size;
    ovf_d   = e_ovf;
    br_d    = e_br;

    acc_new  = e_acc | ({6'd0, pix_i.blue[0], pix_i.green[0]} << {e_phase, 1'b0});
    chr      = acc_new - rotation_i;
    prod     = ({4'd0, e_size} << 3) + ({4'd0, e_size} << 1) + (SIZE_W+4)'(chr[3:0]);
    br_dec   = (e_br != '0) ? e_br - SIZE_W'(1) : '0;
    hdr_end  = 1'b0;
    hdr_err  = 1'b0;
    hdr_code = ERR_NONE;
    fname    = 8'd0;

    emit     = 1'b0;
    step_res = '{out_byte: 8'd0, kind: KIND_HDR_CHAR, error_code: ERR_NONE,
                 payload_size: '0, filename_length: 8'd0, last: 1'b0};

    if (e_mode == MODE_HEADER || e_mode == MODE_MESSAGE) begin
      acc_d = acc_new;
      if (e_phase != 2'd3) begin
        phase_d = e_phase + 2'd1;
        if (pix_i.end_of_image) begin
          mode_d              = MODE_IDLE;
          emit                = 1'b1;
          step_res.kind       = KIND_ERROR;
          step_res.error_code = ERR_TRUNCATED;
          step_res.last       = 1'b1;
        end
      end else begin
        acc_d   = 8'd0;
        phase_d = 2'd0;
        emit    = 1'b1;
        if (e_mode == MODE_MESSAGE) begin
          br_d = br_dec;
          if (br_dec == '0) begin
            mode_d            = MODE_IDLE;
            step_res.out_byte = chr;
            step_res.kind     = KIND_MSG_BYTE;
            step_res.last     = 1'b1;
          end else if (pix_i.end_of_image) begin
            mode_d              = MODE_IDLE;
            step_res.kind       = KIND_ERROR;
            step_res.error_code = ERR_TRUNCATED;
            step_res.last       = 1'b1;
          end else begin
            step_res.out_byte = chr;
            step_res.kind     = KIND_MSG_BYTE;
          end
        end else begin
          hc_d = e_hc + HDR_CNT_W'(1);
          if (e_hc < HDR_CNT_W'(4) && chr != PREFIX[e_hc[1:0]]) begin
            pok_d = 1'b0;
          end
          if (chr inside {[CHAR_ZERO:CHAR_NINE]}) begin
            if (e_run != {RUN_W{1'b1}}) begin
              run_d = e_run + RUN_W'(1);
            end
            if (!e_ovf) begin
              // Accumulating ten times the size plus the digit must stay within 63 bits.
              if (prod > {4'd0, SIZE_MAX}) begin
                ovf_d = 1'b1;
              end else begin
                size_d = prod[SIZE_W-1:0];
              end
            end
          end else if (chr == CHAR_UNDERSCORE && e_run != '0 && hc_d > HDR_CNT_W'(4)) begin
            hdr_end = 1'b1;
            hdr_err = 1'b1;
            if (!pok_d) begin
              hdr_code = ERR_PREFIX;
            end else if (!e_rad || e_delim < HDR_CNT_W'(5)) begin
              hdr_code = ERR_NO_DELIM;
            end else if (32'(e_run) >= SIZE_DIGIT_LIMIT) begin
              hdr_code = ERR_DIGITS;
            end else if (e_ovf) begin
              hdr_code = ERR_OVERFLOW;
            end else if (e_size == '0) begin
              hdr_code = ERR_ZERO_SIZE;
            end else if (32'(e_delim) - 32'd4 >= FILENAME_LIMIT) begin
              hdr_code = ERR_FILENAME;
            end else begin
              hdr_err = 1'b0;
              fname   = 8'(32'(e_delim) - 32'd4);
            end
          end else if (chr == CHAR_UNDERSCORE) begin
            rad_d   = 1'b1;
            delim_d = e_hc;
            run_d   = '0;
            size_d  = '0;
            ovf_d   = 1'b0;
          end else begin
            rad_d  = 1'b0;
            run_d  = '0;
            size_d = '0;
            ovf_d  = 1'b0;
          end

          if (!hdr_end && 32'(hc_d) >= HEADER_LIMIT - 1) begin
            hdr_err  = 1'b1;
            hdr_code = ERR_OVERLONG;
          end

          // A header error outranks truncation; truncation outranks everything else.
          if (hdr_err) begin
            mode_d              = MODE_IDLE;
            step_res.out_byte   = chr;
            step_res.kind       = KIND_ERROR;
            step_res.error_code = hdr_code;
            step_res.last       = 1'b1;
          end else if (pix_i.end_of_image) begin
            mode_d              = MODE_IDLE;
            step_res.kind       = KIND_ERROR;
            step_res.error_code = ERR_TRUNCATED;
            step_res.last       = 1'b1;
          end else if (hdr_end) begin
            mode_d                   = MODE_MESSAGE;
            br_d                     = e_size;
            step_res.out_byte        = chr;
            step_res.kind            = KIND_HDR_DONE;
            step_res.payload_size    = e_size;
            step_res.filename_length = fname;
          end else begin
            step_res.out_byte = chr;
          end
        end
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (pix_ready_o) begin
      res_valid_d = fire && emit;
      res_d       = step_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      acc_q       <= 8'd0;
      mode_q      <= MODE_HEADER;
      hc_q        <= '0;
      pok_q       <= 1'b1;
      run_q       <= '0;
      rad_q       <= 1'b0;
      delim_q     <= '0;
      size_q      <= '0;
      ovf_q       <= 1'b0;
      br_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        mode_q  <= mode_d;
        hc_q    <= hc_d;
        pok_q   <= pok_d;
        run_q   <= run_d;
        rad_q   <= rad_d;
        delim_q <= delim_d;
        size_q  <= size_d;
        ovf_q   <= ovf_d;
        br_q    <= br_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/lsb_stego_pixel_decoder.sv]
// Top level of the pixel decoder: channels, rotation register and the two stages.
//
//   Channel   Direction  Carries
//   pix_i     in         green, blue, start_of_image, end_of_image (one pixel)
//   res_o     out        out_byte, kind, error_code, payload_size, filename_length, last
//   cfg_i     in         rotation (always ready)
//
// Each pixel is registered in the input register and then in the decode core's result
// register before its result can be transferred; one pixel is taken per cycle while the
// results are not stalled. The rate is set by the single decode step from decoder state to result register.
// Reset clears the decoder to header mode and the rotation to zero.
// A stalled result holds the core, and the input register then fills and drops ready.
module lsb_stego_pixel_decoder
  import lsd_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  lsd_pixel_if.sink    pix_i,
  lsd_cfg_if.sink      cfg_i,
  lsd_result_if.source res_o
);

  logic [7:0] rotation_q;
  pixel_t     in_pixel;
  pixel_t     core_pixel;
  logic       core_valid;
  logic       core_ready;
  result_t    result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= 8'd0;
    end else if (cfg_i.valid) begin
      rotation_q <= cfg_i.rotation;
    end
  end

  assign in_pixel = '{green: pix_i.green, blue: pix_i.blue,
                      start_of_image: pix_i.start_of_image,
                      end_of_image: pix_i.end_of_image};

  lsd_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .in_pixel_i  (in_pixel),
    .out_valid_o (core_valid),
    .out_ready_i (core_ready),
    .out_pixel_o (core_pixel)
  );

  lsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rotation_i  (rotation_q),
    .pix_valid_i (core_valid),
    .pix_ready_o (core_ready),
    .pix_i       (core_pixel),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (result)
  );

  assign res_o.out_byte        = result.out_byte;
  assign res_o.kind            = result.kind;
  assign res_o.error_code      = result.error_code;
  assign res_o.payload_size    = result.payload_size;
  assign res_o.filename_length = result.filename_length;
  assign res_o.last            = result.last;

endmodule

[verif/lsb_stego_pixel_decoder_tb.sv]
// Self-checking testbench of the pixel decoder: directed headers, random images, stalls.
`timescale 1ns / 100ps

module lsb_stego_pixel_decoder_tb;
  import lsd_pkg::*;

  localparam int CYCLE_LIMIT      = 100_000;
  localparam int HOLD_CYCLES      = 200;
  localparam int PIXELS_PER_PHASE = 30;
  localparam int NO_EOF           = -1;

  typedef enum bit [1:0] {IMG_HEADER, IMG_MESSAGE, IMG_IDLE} image_mode_e;

  class decode_tracker;
    result_t           awaited_results[$];
    bit [7:0]          rotation;
    bit [1:0]          phase;
    bit [7:0]          acc;
    image_mode_e       mode;
    int unsigned       hdr_count;
    bit                prefix_good;
    int unsigned       digit_run;
    bit                after_delim;
    int unsigned       delim_idx;
    longint unsigned   size_acc;
    bit                size_ovf;
    bit [SIZE_W-1:0]   remaining;
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       kind_count[4];
    bit [15:0]         codes_seen;

    function new();
      rotation = 8'd0;
      restart();
    endfunction

    function void restart();
      phase       = 2'd0;
      acc         = 8'd0;
      mode        = IMG_HEADER;
      hdr_count   = 0;
      prefix_good = 1'b1;
      digit_run   = 0;
      after_delim = 1'b0;
      delim_idx   = 0;
      size_acc    = 0;
      size_ovf    = 1'b0;
      remaining   = '0;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function void emit(bit [7:0] b, kind_e k, err_e e, bit [SIZE_W-1:0] sz, bit [7:0] fl,
                       bit lst);
      result_t r;
      r.out_byte        = b;
      r.kind            = k;
      r.error_code      = e;
      r.payload_size    = sz;
      r.filename_length = fl;
      r.last            = lst;
      awaited_results.push_back(r);
    endfunction

    // Parses one header character. Returns KIND_HDR_CHAR while the header goes on.
    function kind_e take_header_char(bit [7:0] c, output err_e code, output bit [7:0] fname);
      int unsigned     idx;
      longint unsigned digit;
      code  = ERR_NONE;
      fname = 8'd0;
      idx   = hdr_count;
      hdr_count++;
      if (idx < 4 && c != PREFIX[idx]) prefix_good = 1'b0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        digit = c - CHAR_ZERO;
        if (digit_run < 63) digit_run++;
        if (!size_ovf) begin
          if (size_acc > (SIZE_MAX - digit) / 10) size_ovf = 1'b1;
          else size_acc = size_acc * 10 + digit;
        end
      end else if (c == CHAR_UNDERSCORE && digit_run > 0 && hdr_count > 4) begin
        if (!prefix_good) code = ERR_PREFIX;
        else if (!after_delim || delim_idx < 5) code = ERR_NO_DELIM;
        else if (digit_run >= SIZE_DIGIT_LIMIT) code = ERR_DIGITS;
        else if (size_ovf) code = ERR_OVERFLOW;
        else if (size_acc == 0) code = ERR_ZERO_SIZE;
        else if (delim_idx - 4 >= FILENAME_LIMIT) code = ERR_FILENAME;
        if (code != ERR_NONE) return KIND_ERROR;
        fname = 8'(delim_idx - 4);
        return KIND_HDR_DONE;
      end else if (c == CHAR_UNDERSCORE) begin
        after_delim = 1'b1;
        delim_idx   = idx;
        digit_run   = 0;
        size_acc    = 0;
        size_ovf    = 1'b0;
      end else begin
        after_delim = 1'b0;
        digit_run   = 0;
        size_acc    = 0;
        size_ovf    = 1'b0;
      end
      if (hdr_count >= HEADER_LIMIT - 1) begin
        code = ERR_OVERLONG;
        return KIND_ERROR;
      end
      return KIND_HDR_CHAR;
    endfunction

    function void note_pixel(pixel_t p);
      bit [7:0] c;
      kind_e    k;
      err_e     code;
      bit [7:0] fname;
      if (p.start_of_image) restart();
      if (mode == IMG_IDLE) return;
      acc[2*phase +: 2] = {p.blue[0], p.green[0]};
      if (phase < 3) begin
        phase++;
        if (p.end_of_image) begin
          mode = IMG_IDLE;
          emit(8'd0, KIND_ERROR, ERR_TRUNCATED, '0, 8'd0, 1'b1);
        end
        return;
      end
      c     = acc - rotation;
      acc   = 8'd0;
      phase = 2'd0;
      if (mode == IMG_MESSAGE) begin
        if (remaining > 0) remaining--;
        if (remaining == 0) begin
          mode = IMG_IDLE;
          emit(c, KIND_MSG_BYTE, ERR_NONE, '0, 8'd0, 1'b1);
        end else if (p.end_of_image) begin
          mode = IMG_IDLE;
          emit(8'd0, KIND_ERROR, ERR_TRUNCATED, '0, 8'd0, 1'b1);
        end else begin
          emit(c, KIND_MSG_BYTE, ERR_NONE, '0, 8'd0, 1'b0);
        end
        return;
      end
      k = take_header_char(c, code, fname);
      // A header error on the final pixel takes precedence over the truncation.
      if (k == KIND_ERROR) begin
        mode = IMG_IDLE;
        emit(c, KIND_ERROR, code, '0, 8'd0, 1'b1);
      end else if (p.end_of_image) begin
        mode = IMG_IDLE;
        emit(8'd0, KIND_ERROR, ERR_TRUNCATED, '0, 8'd0, 1'b1);
      end else if (k == KIND_HDR_DONE) begin
        mode      = IMG_MESSAGE;
        remaining = size_acc[SIZE_W-1:0];
        emit(c, KIND_HDR_DONE, ERR_NONE, size_acc[SIZE_W-1:0], fname, 1'b0);
      end else begin
        emit(c, KIND_HDR_CHAR, ERR_NONE, '0, 8'd0, 1'b0);
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("MISMATCH: %s", what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("result with nothing awaited: byte %0h kind %0d code %0d",
                         got.out_byte, got.kind, got.error_code));
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      kind_count[want.kind]++;
      codes_seen[want.error_code] = 1'b1;
      if (got.out_byte !== want.out_byte)
        report($sformatf("result %0d: out_byte %0h, awaited %0h", checked, got.out_byte,
                         want.out_byte));
      if (got.kind !== want.kind)
        report($sformatf("result %0d: kind %0d, awaited %0d", checked, got.kind, want.kind));
      if (got.error_code !== want.error_code)
        report($sformatf("result %0d: error_code %0d, awaited %0d", checked, got.error_code,
                         want.error_code));
      if (got.payload_size !== want.payload_size)
        report($sformatf("result %0d: payload_size %0d, awaited %0d", checked,
                         got.payload_size, want.payload_size));
      if (got.filename_length !== want.filename_length)
        report($sformatf("result %0d: filename_length %0d, awaited %0d", checked,
                         got.filename_length, want.filename_length));
      if (got.last !== want.last)
        report($sformatf("result %0d: last %0b, awaited %0b", checked, got.last, want.last));
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lsd_pixel_if  pix ();
  lsd_cfg_if    cfg ();
  lsd_result_if res ();

  lsb_stego_pixel_decoder DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix),
    .cfg_i (cfg),
    .res_o (res)
  );

  decode_tracker sb = new();

  bit [7:0] image_bytes[$];
  bit [7:0] cur_rotation  = 8'd0;
  int       send_idle_pct = 0;
  int       stall_pct     = 0;
  int       hold_token    = 0;
  int       hold_seen     = 0;
  int       hold_left     = 0;
  int       pixels_sent   = 0;
  int       cycle_count   = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results awaited", cycle_count, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: checks every transfer and drives ready, with a long hold-off on request.
  always @(posedge clk_i) begin : result_sink
    result_t got;
    if (rst_ni && res.valid && res.ready) begin
      got.out_byte        = res.out_byte;
      got.kind            = kind_e'(res.kind);
      got.error_code      = err_e'(res.error_code);
      got.payload_size    = res.payload_size;
      got.filename_length = res.filename_length;
      got.last            = res.last;
      sb.check_result(got);
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_pixel(input bit [7:0] green, input bit [7:0] blue, input bit sof,
                            input bit eof);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid          <= 1'b1;
    pix.green          <= green;
    pix.blue           <= blue;
    pix.start_of_image <= sof;
    pix.end_of_image   <= eof;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    sb.note_pixel(pixel_t'({green, blue, sof, eof}));
    pixels_sent++;
  endtask

  // Sends the bytes of the image, two hidden bits per pixel, and stops after eof_pixel.
  task automatic send_image(input int eof_pixel);
    bit [7:0] raw;
    int       pidx;
    for (int i = 0; i < image_bytes.size(); i++) begin
      raw = image_bytes[i] + cur_rotation;
      for (int k = 0; k < 4; k++) begin
        pidx = 4 * i + k;
        send_pixel({7'($urandom), raw[2*k]}, {7'($urandom), raw[2*k+1]}, pidx == 0,
                   pidx == eof_pixel);
        if (pidx == eof_pixel) return;
      end
    end
  endtask

  task automatic send_noise(input int count, input int sof_pct);
    for (int i = 0; i < count; i++)
      send_pixel(8'($urandom), 8'($urandom), $urandom_range(99) < sof_pct,
                 $urandom_range(99) < 20);
  endtask

  task automatic wait_drained();
    pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // A pixel that yields no result may still sit in the pipeline.
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rotation(input bit [7:0] value);
    cfg.valid    <= 1'b1;
    cfg.rotation <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid    <= 1'b0;
    cur_rotation = value;
    sb.rotation  = value;
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) image_bytes.push_back(s.getc(i));
  endfunction

  function automatic void add_repeat(input bit [7:0] ch, input int count);
    repeat (count) image_bytes.push_back(ch);
  endfunction

  function automatic void add_random(input int count);
    repeat (count) image_bytes.push_back(8'($urandom));
  endfunction

  // Mostly letters; the odd dot, underscore, digit or dash makes the parser work harder.
  function automatic void add_name(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(15);
      if (r < 12) image_bytes.push_back(8'h61 + 8'($urandom_range(25)));
      else if (r == 12) image_bytes.push_back(8'h2E);
      else if (r == 13) image_bytes.push_back(CHAR_UNDERSCORE);
      else if (r == 14) image_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      else image_bytes.push_back(8'h2D);
    end
  endfunction

  function automatic void make_image(input string header, input int msg_len);
    image_bytes.delete();
    add_text(header);
    add_random(msg_len);
  endfunction

  function automatic int last_pixel();
    return 4 * image_bytes.size() - 1;
  endfunction

  task automatic random_image();
    int    pick;
    int    size;
    int    eof_at;
    string size_text;
    pick = $urandom_range(99);
    size = $urandom_range(1, 9);
    size_text = ($urandom_range(4) == 0) ? $sformatf("0%0d", size) : $sformatf("%0d", size);
    image_bytes.delete();
    add_text("png_");
    add_name($urandom_range(1, 4));
    add_text({"_", size_text, "_"});
    add_random(size);
    if (pick < 12) image_bytes[$urandom_range(image_bytes.size() - 1)] = 8'($urandom);
    else if (pick < 20) begin
      image_bytes.delete();
      add_random($urandom_range(2, 12));
    end
    eof_at = $urandom_range(1) ? last_pixel() : NO_EOF;
    if (pick >= 20 && pick < 35) eof_at = $urandom_range(last_pixel());
    send_image(eof_at);
    if ($urandom_range(3) == 0) send_noise($urandom_range(1, 6), 10);
  endtask

  initial begin : stimulus
    string codes;
    int    phase_start;
    pix.valid          <= 1'b0;
    pix.green          <= 8'd0;
    pix.blue           <= 8'd0;
    pix.start_of_image <= 1'b0;
    pix.end_of_image   <= 1'b0;
    cfg.valid          <= 1'b0;
    cfg.rotation       <= 8'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed images, no idling.
    write_rotation(8'h00);
    make_image("png_a_3_", 0);
    image_bytes.push_back(8'h00);
    image_bytes.push_back(8'hFF);
    image_bytes.push_back(8'h5A);
    send_image(last_pixel());
    send_noise(8, 0);
    make_image("png_f_9223372036854775808_", 0);
    send_image(NO_EOF);
    make_image("png_f_0_", 0);
    send_image(NO_EOF);
    image_bytes.delete();
    add_text("png_f_");
    add_repeat(CHAR_ZERO + 8'd1, 32);
    add_text("_");
    send_image(NO_EOF);
    make_image("pNg_a_1_", 1);
    send_image(NO_EOF);
    make_image("png_12_", 0);
    send_image(last_pixel());
    make_image("png_a_2_", 2);
    send_image(4 * 8 - 1);
    make_image("png_a_1_", 1);
    send_image(0);
    make_image("png_a_4_", 4);
    send_image(4 * 9 + 2);

    // Random images over four idling patterns; the first starts under a long hold-off.
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_rotation(8'($urandom_range(1, 254)));
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          write_rotation(8'hFF);
          send_idle_pct = 86;
          stall_pct     = 0;
        end
        2: begin
          write_rotation(8'h00);
          send_idle_pct = 0;
          stall_pct     = 86;
        end
        default: begin
          write_rotation(8'($urandom));
          send_idle_pct = 33;
          stall_pct     = 33;
        end
      endcase
      phase_start = pixels_sent;
      if (ph == 0) begin
        hold_token <= hold_token + 1;
        make_image("png_hold_3_", 3);
        send_image(last_pixel());
      end
      while (pixels_sent - phase_start < PIXELS_PER_PHASE) begin
        random_image();
        if (ph == 1 && pixels_sent - phase_start < 60) wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    codes = "";
    for (int i = 1; i < 9; i++)
      if (sb.codes_seen[i]) codes = {codes, $sformatf(" %0d", i)};
    $display("Run covered %0d pixels, %0d results: %0d header chars, %0d accepted headers,",
             pixels_sent, sb.checked, sb.kind_count[KIND_HDR_CHAR],
             sb.kind_count[KIND_HDR_DONE]);
    $display("%0d message bytes and %0d errors (codes%s), with %0d mismatches.",
             sb.kind_count[KIND_MSG_BYTE], sb.kind_count[KIND_ERROR], codes, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lsd_pkg.sv
rtl/lsd_if.sv
rtl/lsd_in_stage.sv
rtl/lsd_core.sv
rtl/lsb_stego_pixel_decoder.sv
verif/lsb_stego_pixel_decoder_tb.sv
